/* src/dqdd_pkg.sv */
// Shared types and constants for the dual quadrature detent decoder.
// No dependencies; imported by every module of the block.
package dqdd_pkg;

   localparam int unsigned NumEnc = 2;
   localparam int unsigned SelW   = 1;

   // phase pair codes (active low, {high bit, low bit})
   localparam logic [1:0] PAIR_HOME = 2'b11;
   localparam logic [1:0] PAIR_CW   = 2'b10;
   localparam logic [1:0] PAIR_CCW  = 2'b01;

   // direction codes, two's complement
   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_CW   = 2'b01;
   localparam logic [1:0] DIR_CCW  = 2'b11;

   typedef struct packed {
      logic [1:0] last_phase;
      logic [1:0] turn_dir;
      logic       armed;
   } enc_state_type;

   localparam enc_state_type ENC_RESET = '{
      last_phase: PAIR_HOME,
      turn_dir:   DIR_NONE,
      armed:      1'b0
   };

endpackage

/* src/dqdd_rules.sv */
// Detent rule logic for one encoder: next state and step from current state and pair.
// Depends on dqdd_pkg.
module dqdd_rules
   import dqdd_pkg::*;
(
   input  enc_state_type     cur_state,
   input  logic [1:0]        pair,
   output enc_state_type     nxt_state,
   output logic signed [1:0] step
);

   always_comb begin
      logic [1:0] last;
      logic [1:0] dir;
      logic       arm;
      logic [1:0] stp;
      last = cur_state.last_phase;
      dir  = cur_state.turn_dir;
      arm  = cur_state.armed;
      stp  = DIR_NONE;
      if (last != pair) begin
         if (last == PAIR_HOME && pair == PAIR_CW) begin
            last = pair;
            dir  = DIR_CW;
            arm  = 1'b0;
         end
         if (last == PAIR_HOME && pair == PAIR_CCW) begin
            last = pair;
            dir  = DIR_CCW;
            arm  = 1'b0;
         end
         // opposite phase reached: arm
         if ((dir == DIR_CCW && pair == PAIR_CW) || (dir == DIR_CW && pair == PAIR_CCW)) begin
            arm  = 1'b1;
            last = pair;
         end
         // back to the first phase: disarm
         if ((dir == DIR_CCW && pair == PAIR_CCW) || (dir == DIR_CW && pair == PAIR_CW)) begin
            arm  = 1'b0;
            last = pair;
         end
         if (pair == PAIR_HOME && arm) begin
            arm  = 1'b0;
            last = pair;
            stp  = dir;
         end else if (pair == PAIR_HOME && dir != DIR_NONE) begin
            arm  = 1'b0;
            dir  = DIR_NONE;
            last = pair;
         end
      end
      nxt_state.last_phase = last;
      nxt_state.turn_dir   = dir;
      nxt_state.armed      = arm;
      step                 = stp;
   end

endmodule

/* src/dqdd_enc_bank.sv */
// Per-encoder state registers with one write port and one read port.
// Depends on dqdd_pkg.
module dqdd_enc_bank
   import dqdd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  logic [SelW-1:0] wr_sel,
   input  enc_state_type   wr_state,
   input  logic [SelW-1:0] rd_sel,
   output enc_state_type   rd_state
);

   enc_state_type enc_ff [NumEnc];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumEnc; i++) begin
            enc_ff[i] <= ENC_RESET;
         end
      end else if (wr_en) begin
         enc_ff[wr_sel] <= wr_state;
      end
   end

   assign rd_state = enc_ff[rd_sel];

endmodule

/* src/dual_quadrature_detent_decoder.sv */
// Dual quadrature detent decoder, top level.
// Path: a req beat enters the input register, then the result register, which drives rsp_valid;
// rsp_ready low holds the result register and, once the input register is full, req_ready.
// Throughput: one beat per cycle unless rsp_ready stalls; the encoder state is written
// as an item enters the result register, so the next item already sees it.
// Reset: synchronous, active high; both encoders return home, no direction, disarmed.
// Depends on dqdd_pkg, dqdd_rules, dqdd_enc_bank.
module dual_quadrature_detent_decoder
   import dqdd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [3:0]        req_sample,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [1:0] rsp_step
);

   logic              in_valid_ff, in_valid_in;
   logic [SelW-1:0]   in_op_ff;
   logic [1:0]        in_pair_ff;
   logic              out_valid_ff, out_valid_in;
   logic signed [1:0] out_step_ff;
   logic              advance;
   enc_state_type     cur_state;
   enc_state_type     nxt_state;
   logic signed [1:0] step_in;

   // result register free or draining this cycle
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_op_ff <= '0;
      end else if (req_valid && req_ready) begin
         in_op_ff   <= req_op;
         in_pair_ff <= req_op ? req_sample[3:2] : req_sample[1:0];
      end
      if (advance && in_valid_ff) begin
         out_step_ff <= step_in;
      end
   end

   dqdd_enc_bank u_bank (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (advance && in_valid_ff),
      .wr_sel   (in_op_ff),
      .wr_state (nxt_state),
      .rd_sel   (in_op_ff),
      .rd_state (cur_state)
   );

   dqdd_rules u_rules (
      .cur_state (cur_state),
      .pair      (in_pair_ff),
      .nxt_state (nxt_state),
      .step      (step_in)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_step  = out_step_ff;

   // a completed detent can only come from an armed encoder landing home
   a_step_needs_arm: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && step_in != 2'sb00) |-> (cur_state.armed && in_pair_ff == PAIR_HOME))
      else $error("step without armed encoder");

   a_step_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_step_ff != 2'sb10))
      else $error("invalid step code");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled without back-pressure");

   a_reset_home: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (cur_state == ENC_RESET))
      else $error("encoder state not home after reset");

endmodule

/* bench/dual_quadrature_detent_decoder_tb.sv */
// Self-checking bench for dual_quadrature_detent_decoder: a scripted set of detent trips,
// then random trips and noise on both encoders, checked against a local decoder model.
// Depends on dqdd_pkg and the decoder RTL.
module dual_quadrature_detent_decoder_tb;
   import dqdd_pkg::*;

   localparam int ScriptLen   = 26;
   localparam int HoldCycles  = 150;
   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 8;
   localparam int MaxReports  = 10;

   // both phases active; the package has no name for it
   localparam logic [1:0] PAIR_BOTH = 2'b00;

   typedef struct packed {
      logic              op;
      logic [3:0]        smp;
      logic              fixed;
      logic signed [1:0] want;
   } script_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_ready;
   logic              req_op     = 1'b0;
   logic [3:0]        req_sample = 4'h0;
   logic              rsp_valid;
   logic              rsp_ready  = 1'b0;
   logic signed [1:0] rsp_step;

   dual_quadrature_detent_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_step   (rsp_step)
   );

   enc_state_type     enc_model [NumEnc];
   logic signed [1:0] pending_steps [$];
   logic              drv_fixed = 1'b0;
   logic signed [1:0] drv_want  = 2'sb00;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int faults        = 0;
   int beats_in      = 0;
   int beats_out     = 0;
   int cw_seen       = 0;
   int ccw_seen      = 0;
   int stall_cycles  = 0;

   script_row_type detent_script [ScriptLen] = '{
      '{1'b0, 4'hF, 1'b1, DIR_NONE},   // home after reset, nothing to do
      '{1'b1, 4'hF, 1'b1, DIR_NONE},
      '{1'b0, 4'h0, 1'b1, DIR_NONE},   // both phases low straight from home
      '{1'b1, 4'h0, 1'b1, DIR_NONE},
      '{1'b0, 4'hE, 1'b0, DIR_NONE},   // clockwise detent on encoder 0
      '{1'b0, 4'hD, 1'b0, DIR_NONE},
      '{1'b0, 4'hF, 1'b0, DIR_NONE},
      '{1'b1, 4'h7, 1'b0, DIR_NONE},   // anticlockwise detent on encoder 1
      '{1'b1, 4'hB, 1'b0, DIR_NONE},
      '{1'b1, 4'hF, 1'b0, DIR_NONE},
      '{1'b0, 4'hE, 1'b0, DIR_NONE},   // back home unarmed
      '{1'b0, 4'hF, 1'b0, DIR_NONE},
      '{1'b0, 4'hE, 1'b0, DIR_NONE},   // arm, then step back and disarm
      '{1'b0, 4'hD, 1'b0, DIR_NONE},
      '{1'b0, 4'hE, 1'b0, DIR_NONE},
      '{1'b0, 4'hF, 1'b0, DIR_NONE},
      '{1'b0, 4'h1, 1'b0, DIR_NONE},   // glitch to 00 mid-trip is ignored
      '{1'b0, 4'h0, 1'b0, DIR_NONE},
      '{1'b0, 4'h2, 1'b0, DIR_NONE},
      '{1'b0, 4'h3, 1'b0, DIR_NONE},
      '{1'b1, 4'hC, 1'b0, DIR_NONE},   // clockwise detent on encoder 1 with a bounce, other bits low
      '{1'b1, 4'h8, 1'b0, DIR_NONE},
      '{1'b1, 4'h4, 1'b0, DIR_NONE},
      '{1'b1, 4'h8, 1'b0, DIR_NONE},
      '{1'b1, 4'h4, 1'b0, DIR_NONE},
      '{1'b1, 4'hC, 1'b0, DIR_NONE}
   };

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic signed [1:0] predict_detent(input logic sel, input logic [3:0] smp);
      enc_state_type     st;
      logic [1:0]        p;
      logic signed [1:0] step;
      st   = enc_model[sel];
      p    = sel ? smp[3:2] : smp[1:0];
      step = DIR_NONE;
      if (st.last_phase != p) begin
         if (st.last_phase == PAIR_HOME && p == PAIR_CW) begin
            st.last_phase = p;
            st.turn_dir   = DIR_CW;
            st.armed      = 1'b0;
         end
         if (st.last_phase == PAIR_HOME && p == PAIR_CCW) begin
            st.last_phase = p;
            st.turn_dir   = DIR_CCW;
            st.armed      = 1'b0;
         end
         // opposite phase arms, the leading phase again disarms
         if ((st.turn_dir == DIR_CCW && p == PAIR_CW) ||
             (st.turn_dir == DIR_CW && p == PAIR_CCW)) begin
            st.armed      = 1'b1;
            st.last_phase = p;
         end
         if ((st.turn_dir == DIR_CCW && p == PAIR_CCW) ||
             (st.turn_dir == DIR_CW && p == PAIR_CW)) begin
            st.armed      = 1'b0;
            st.last_phase = p;
         end
         if (p == PAIR_HOME && st.armed) begin
            st.armed      = 1'b0;
            st.last_phase = p;
            step          = st.turn_dir;
         end else if (p == PAIR_HOME && st.turn_dir != DIR_NONE) begin
            st.armed      = 1'b0;
            st.turn_dir   = DIR_NONE;
            st.last_phase = p;
         end
         enc_model[sel] = st;
      end
      return step;
   endfunction

   task automatic report_fault(input string what, input logic [1:0] want, input logic [1:0] got);
      faults++;
      if (faults <= MaxReports)
         $display("MISMATCH rsp beat %0d: %s, expected %0d got %0d",
                  beats_out, what, $signed(want), $signed(got));
   endtask

   // check and predict on the same edge; checks first so ordering is fixed
   always @(posedge clock) begin : monitor
      logic signed [1:0] want;
      logic              moved;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         moved = (rsp_valid && rsp_ready) || (req_valid && req_ready);
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (rsp_step == DIR_CW)
               cw_seen++;
            else if (rsp_step == DIR_CCW)
               ccw_seen++;
            if (pending_steps.size() == 0) begin
               report_fault("beat with nothing pending", 2'bxx, rsp_step);
            end else begin
               want = pending_steps.pop_front();
               if (rsp_step !== want)
                  report_fault("step", want, rsp_step);
            end
         end
         if (req_valid && req_ready) begin
            beats_in++;
            want = predict_detent(req_op, req_sample);
            pending_steps.push_back(drv_fixed ? drv_want : want);
         end
         if (moved)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("watchdog: %0d cycles without a beat", stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_beat(input logic op, input logic [3:0] smp,
                            input logic fixed, input logic signed [1:0] want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      drv_fixed = fixed;
      drv_want  = want;
      req_valid  <= 1'b1;
      req_op     <= op;
      req_sample <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_pair(input logic sel, input logic [1:0] pair);
      logic [3:0] smp;
      smp = 4'($urandom_range(15));
      if (sel)
         smp[3:2] = pair;
      else
         smp[1:0] = pair;
      send_beat(sel, smp, 1'b0, DIR_NONE);
   endtask

   // mostly complete detent trips with random bounces, some broken trips, some noise
   task automatic run_random(input int count);
      int         sent;
      int         kind;
      logic       sel;
      logic       noisy;
      logic [1:0] lead;
      logic [1:0] trip [$];
      sent = 0;
      while (sent < count) begin
         trip  = {};
         sel   = 1'($urandom_range(1));
         lead  = $urandom_range(1) ? PAIR_CW : PAIR_CCW;
         kind  = $urandom_range(99);
         noisy = (kind >= 85);
         if (kind < 70) begin
            trip.push_back(PAIR_HOME);
            trip.push_back(lead);
            case ($urandom_range(3))
               0: trip.push_back(lead);
               1: trip.push_back(PAIR_BOTH);
               default: ;
            endcase
            trip.push_back(~lead);
            if ($urandom_range(3) == 0) begin
               trip.push_back(lead);
               trip.push_back(~lead);
            end
            trip.push_back(PAIR_HOME);
         end else if (!noisy) begin
            trip.push_back(PAIR_HOME);
            trip.push_back(lead);
            case ($urandom_range(2))
               0: ;
               1: begin
                  trip.push_back(~lead);
                  trip.push_back(lead);
               end
               default: trip.push_back(PAIR_BOTH);
            endcase
            trip.push_back(PAIR_HOME);
         end else begin
            repeat ($urandom_range(4, 1)) trip.push_back(2'($urandom_range(3)));
         end
         foreach (trip[k]) begin
            if (noisy) begin
               send_pair(1'($urandom_range(1)), trip[k]);
            end else begin
               // the other encoder butts in now and then
               if ($urandom_range(9) == 0) begin
                  send_pair(~sel, 2'($urandom_range(3)));
                  sent++;
               end
               send_pair(sel, trip[k]);
            end
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      for (int e = 0; e < NumEnc; e++) enc_model[e] = ENC_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 7;
      recv_idle_pct = 84;
      foreach (detent_script[r])
         send_beat(detent_script[r].op, detent_script[r].smp,
                   detent_script[r].fixed, detent_script[r].want);
      run_random(317);

      send_idle_pct = 84;
      recv_idle_pct = 7;
      run_random(317);

      // flat out, with one long receiver hold-off so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      run_random(316);
      req_valid <= 1'b0;

      while (pending_steps.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d beats in, %0d out; %0d clockwise and %0d anticlockwise detents decoded",
               beats_in, beats_out, cw_seen, ccw_seen);
      $display("both encoders, bounces and glitches, both-side stalls and a %0d-cycle hold-off",
               HoldCycles);
      if (faults == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", faults);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
